// File: src/fwd_bwd_microbatch_grouper_defines.svh
// assertion macros shared by the span grouper modules
`ifndef FWD_BWD_MICROBATCH_GROUPER_DEFINES_SVH
`define FWD_BWD_MICROBATCH_GROUPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FBMG_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, checked outside reset
`define FBMG_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: src/fbmg_pkg.sv
// shared constants and types of the span grouper
`timescale 1ns / 1ps
`default_nettype none
package fbmg_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int TIME_BITS  = 48;
  localparam int TAG_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int PTR_BITS   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_FWD   = 2'd1;
  localparam logic [1:0] KIND_BWD   = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] duration;
    logic [TAG_BITS-1:0]  tag;
    logic                 final_flag;
    logic                 overflow;
  } result_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic                  flush;
    logic [COUNT_BITS-1:0] data;
  } fifo_req_t;

  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [COUNT_BITS-1:0] head;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: src/fbmg_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fbmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/fbmg_count_fifo.sv
// count queue: pointers around a ram, head entry prefetched with write forwarding
`timescale 1ns / 1ps
`default_nettype none
`include "fwd_bwd_microbatch_grouper_defines.svh"
module fbmg_count_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fbmg_pkg::fifo_req_t req,
  output fbmg_pkg::fifo_stat_t    stat
);
  import fbmg_pkg::*;

  logic [PTR_BITS-1:0]   head;
  logic [PTR_BITS-1:0]   head_next;
  logic [PTR_BITS-1:0]   tail;
  logic [PTR_BITS-1:0]   tail_next;
  logic [FILL_BITS-1:0]  fill;
  logic [FILL_BITS-1:0]  fill_next;
  logic [FILL_BITS-1:0]  fill_pushed;
  logic                  do_push;
  logic                  do_pop;
  logic                  bypass;
  logic [COUNT_BITS-1:0] bypass_data;
  logic [COUNT_BITS-1:0] rd_data;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_comb begin
    do_push     = req.push && (fill != FILL_BITS'(FIFO_DEPTH));
    fill_pushed = fill + FILL_BITS'(do_push);
    // the pop sees the push of the same item
    do_pop      = req.pop && (fill_pushed != '0);
    head_next   = do_pop ? ptr_inc(head) : head;
    tail_next   = do_push ? ptr_inc(tail) : tail;
    fill_next   = fill_pushed - FILL_BITS'(do_pop);
    if (req.flush) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      bypass <= 1'b0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      // write landing on the entry being read: use the written value
      bypass <= do_push && (tail == head_next);
    end
    bypass_data <= req.data;
  end

  fbmg_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (do_push),
    .wr_addr(tail),
    .wr_data(req.data),
    .rd_addr(head_next),
    .rd_data(rd_data)
  );

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_BITS'(FIFO_DEPTH));
  assign stat.head  = bypass ? bypass_data : rd_data;

  `FBMG_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= FILL_BITS'(FIFO_DEPTH), "fill above depth")
  `FBMG_ASSERT_NEXT(a_flush_empty, clk, rst, req.flush, fill == '0 && head == tail, "flush left entries")

endmodule
`default_nettype wire

// File: src/fbmg_out_buf.sv
// two-entry output buffer: result register plus skid stage
`timescale 1ns / 1ps
`default_nettype none
module fbmg_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fbmg_pkg::result_t push_data,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fbmg_pkg::result_t      out_data
);
  import fbmg_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: src/fwd_bwd_microbatch_grouper.sv
// top level of the forward/backward micro-batch span grouper
`timescale 1ns / 1ps
`default_nettype none
`include "fwd_bwd_microbatch_grouper_defines.svh"
// Groups forward and backward trace events into spans, one item per clock. Each accepted
// item is resolved in the cycle it is taken: the held span, the inside count and the
// phase live in registers, and the count queue lives in a 16-entry ram whose head entry
// is read ahead every cycle (with forwarding of a write to that entry), so a push and a
// pop of the same item complete in the cycle it is taken and the next item may follow at once.
// Results pass through a result register and a skid stage; in_ready drops only while
// both are full. A finish item emits the held span with out_final set and returns the
// block, queue and overflow flag included, to its reset state in the same cycle.
module fwd_bwd_microbatch_grouper (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           command,
  input  wire logic                           is_forward,
  input  wire logic [fbmg_pkg::TIME_BITS-1:0] node_start,
  input  wire logic [fbmg_pkg::TIME_BITS-1:0] node_duration,
  input  wire logic [fbmg_pkg::TAG_BITS-1:0]  node_tag,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [1:0]                     out_kind,
  output logic      [fbmg_pkg::TIME_BITS-1:0] out_start,
  output logic      [fbmg_pkg::TIME_BITS-1:0] out_duration,
  output logic      [fbmg_pkg::TAG_BITS-1:0]  out_tag,
  output logic                                out_final,
  output logic                                queue_overflow
);
  import fbmg_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_FWD  = 2'd1,
    PH_BWD  = 2'd2
  } phase_t;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [1:0]            held_kind;
  logic [1:0]            held_kind_next;
  logic [TIME_BITS-1:0]  held_start;
  logic [TIME_BITS-1:0]  held_start_next;
  logic [TIME_BITS-1:0]  held_duration;
  logic [TIME_BITS-1:0]  held_duration_next;
  logic [TAG_BITS-1:0]   held_tag;
  logic [TAG_BITS-1:0]   held_tag_next;
  logic [TIME_BITS:0]    held_end;
  logic [TIME_BITS:0]    held_end_next;
  logic                  overflow_seen;
  logic                  overflow_seen_next;

  logic                  act;
  logic [TIME_BITS:0]    ev_end;
  logic [TIME_BITS+1:0]  ext_diff;
  logic [TIME_BITS-1:0]  ext_duration;
  logic                  ev_inside;
  logic [COUNT_BITS-1:0] pop_value;
  logic                  res_push;
  result_t               res;
  result_t               out_data;
  fifo_req_t             freq;
  fifo_stat_t            fstat;
  logic                  buf_room;

  assign act = in_valid && in_ready;
  assign in_ready = buf_room;

  always_comb begin
    ev_end    = {1'b0, node_start} + {1'b0, node_duration};
    ev_inside = (node_start >= held_start) && (ev_end <= held_end);
    ext_diff  = {1'b0, ev_end} - {2'b00, held_start};
    if (ext_diff[TIME_BITS+1]) begin
      ext_duration = '0;
    end else if (ext_diff[TIME_BITS]) begin
      ext_duration = TIME_MAX;
    end else begin
      ext_duration = ext_diff[TIME_BITS-1:0];
    end
  end

  always_comb begin
    phase_next         = phase;
    count_next         = count;
    held_kind_next     = held_kind;
    held_start_next    = held_start;
    held_duration_next = held_duration;
    held_tag_next      = held_tag;
    held_end_next      = held_end;
    overflow_seen_next = overflow_seen;
    freq               = '0;
    freq.data          = count;
    res_push           = 1'b0;
    res.kind           = held_kind;
    res.start          = held_start;
    res.duration       = held_duration;
    res.tag            = held_tag;
    res.final_flag     = 1'b0;
    res.overflow       = overflow_seen;
    pop_value          = '0;

    if (act) begin
      if (command) begin
        res_push           = 1'b1;
        res.final_flag     = 1'b1;
        freq.flush         = 1'b1;
        phase_next         = PH_INIT;
        count_next         = '0;
        held_kind_next     = KIND_EMPTY;
        held_start_next    = '0;
        held_duration_next = '0;
        held_tag_next      = '0;
        held_end_next      = '0;
        overflow_seen_next = 1'b0;
      end else begin
        unique case (phase)
          PH_FWD: begin
            if (is_forward || !ev_inside) begin
              freq.push          = 1'b1;
              overflow_seen_next = overflow_seen || fstat.full;
              res.overflow       = overflow_seen || fstat.full;
              res_push           = 1'b1;
              held_start_next    = node_start;
              held_duration_next = node_duration;
              held_tag_next      = node_tag;
              held_end_next      = ev_end;
              if (is_forward) begin
                count_next     = '0;
                held_kind_next = KIND_FWD;
              end else begin
                // an empty queue hands back the count pushed just now
                freq.pop       = 1'b1;
                pop_value      = fstat.empty ? count : fstat.head;
                count_next     = pop_value;
                held_kind_next = KIND_BWD;
                phase_next     = PH_BWD;
              end
            end else if (count != COUNT_MAX) begin
              count_next = count + COUNT_BITS'(1);
            end
          end
          PH_BWD: begin
            if (is_forward || count <= COUNT_BITS'(1)) begin
              res_push           = 1'b1;
              freq.pop           = 1'b1;
              pop_value          = fstat.empty ? '0 : fstat.head;
              count_next         = pop_value;
              held_start_next    = node_start;
              held_duration_next = node_duration;
              held_tag_next      = node_tag;
              held_end_next      = ev_end;
              if (is_forward) begin
                held_kind_next = KIND_FWD;
                phase_next     = PH_FWD;
              end else begin
                held_kind_next = KIND_BWD;
              end
            end else begin
              held_duration_next = ext_duration;
              count_next         = count - COUNT_BITS'(1);
            end
          end
          default: begin
            // init: a backward item is dropped
            if (is_forward) begin
              held_kind_next     = KIND_FWD;
              held_start_next    = node_start;
              held_duration_next = node_duration;
              held_tag_next      = node_tag;
              held_end_next      = ev_end;
              count_next         = '0;
              phase_next         = PH_FWD;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      count         <= '0;
      held_kind     <= KIND_EMPTY;
      held_start    <= '0;
      held_duration <= '0;
      held_tag      <= '0;
      held_end      <= '0;
      overflow_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      count         <= count_next;
      held_kind     <= held_kind_next;
      held_start    <= held_start_next;
      held_duration <= held_duration_next;
      held_tag      <= held_tag_next;
      held_end      <= held_end_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  fbmg_count_fifo u_fifo (
    .clk (clk),
    .rst (rst),
    .req (freq),
    .stat(fstat)
  );

  fbmg_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .room     (buf_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_kind       = out_data.kind;
  assign out_start      = out_data.start;
  assign out_duration   = out_data.duration;
  assign out_tag        = out_data.tag;
  assign out_final      = out_data.final_flag;
  assign queue_overflow = out_data.overflow;

  `FBMG_ASSERT_IMPLY(a_init_empty, clk, rst, phase == PH_INIT, held_kind == KIND_EMPTY, "init phase holds a span")
  `FBMG_ASSERT_IMPLY(a_fwd_kind, clk, rst, phase == PH_FWD, held_kind == KIND_FWD, "forward phase holds a non-forward span")
  `FBMG_ASSERT_NEXT(a_finish_reset, clk, rst, act && command, phase == PH_INIT && !overflow_seen, "finish did not reset")

endmodule
`default_nettype wire

// File: verif/tb_fwd_bwd_microbatch_grouper.sv
// testbench for the forward/backward micro-batch span grouper
`timescale 1ns / 1ps
module tb_fwd_bwd_microbatch_grouper;
  import fbmg_pkg::*;

  localparam logic [TIME_BITS-1:0] T_MAX = '1;
  localparam int RANDOM_ITEMS = 1860;

  typedef enum logic [1:0] {PH_INIT, PH_FWD, PH_BWD} phase_e;

  class span_scoreboard;
    phase_e phase;
    logic [COUNT_BITS-1:0] inside_cnt;
    result_t held;
    logic [COUNT_BITS-1:0] count_ram [FIFO_DEPTH];
    int rd_ptr;
    int wr_ptr;
    int fill;
    logic overflow_flag;
    result_t spans_due[$];
    int mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      phase = PH_INIT;
      inside_cnt = '0;
      held = '0;
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      overflow_flag = 1'b0;
    endfunction

    function void push_count(logic [COUNT_BITS-1:0] c);
      if (fill >= FIFO_DEPTH) begin
        overflow_flag = 1'b1;
      end else begin
        count_ram[wr_ptr] = c;
        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
        fill++;
      end
    endfunction

    function logic [COUNT_BITS-1:0] pop_count();
      logic [COUNT_BITS-1:0] c;
      c = '0;
      if (fill > 0) begin
        c = count_ram[rd_ptr];
        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        fill--;
      end
      return c;
    endfunction

    function void emit_held(logic fin);
      result_t r;
      r = held;
      r.final_flag = fin;
      r.overflow = overflow_flag;
      spans_due.insert(spans_due.size(), r);
    endfunction

    function void hold_span(logic [1:0] kind, logic [TIME_BITS-1:0] s,
                            logic [TIME_BITS-1:0] d, logic [TAG_BITS-1:0] t);
      held.kind = kind;
      held.start = s;
      held.duration = d;
      held.tag = t;
    endfunction

    // works out the span, if any, that one accepted item releases
    function void predict_span(logic cmd, logic fwd, logic [TIME_BITS-1:0] s,
                               logic [TIME_BITS-1:0] d, logic [TAG_BITS-1:0] t);
      logic [TIME_BITS:0] ev_end;
      logic [TIME_BITS:0] span_end;
      logic [TIME_BITS:0] diff;
      ev_end = {1'b0, s} + {1'b0, d};
      span_end = {1'b0, held.start} + {1'b0, held.duration};
      if (cmd) begin
        emit_held(1'b1);
        clear_state();
      end else if (phase == PH_FWD && fwd) begin
        push_count(inside_cnt);
        emit_held(1'b0);
        inside_cnt = '0;
        hold_span(KIND_FWD, s, d, t);
      end else if (phase == PH_FWD && s >= held.start && ev_end <= span_end) begin
        if (inside_cnt != '1) inside_cnt++;
      end else if (phase == PH_FWD) begin
        push_count(inside_cnt);
        emit_held(1'b0);
        inside_cnt = pop_count();
        hold_span(KIND_BWD, s, d, t);
        phase = PH_BWD;
      end else if (phase == PH_BWD && fwd) begin
        emit_held(1'b0);
        inside_cnt = pop_count();
        hold_span(KIND_FWD, s, d, t);
        phase = PH_FWD;
      end else if (phase == PH_BWD && inside_cnt <= 1) begin
        emit_held(1'b0);
        inside_cnt = pop_count();
        hold_span(KIND_BWD, s, d, t);
      end else if (phase == PH_BWD) begin
        // stretch the backward span, clamped to the time range
        if (ev_end < {1'b0, held.start}) begin
          held.duration = '0;
        end else begin
          diff = ev_end - {1'b0, held.start};
          held.duration = diff[TIME_BITS] ? T_MAX : diff[TIME_BITS-1:0];
        end
        inside_cnt--;
      end else if (fwd) begin
        hold_span(KIND_FWD, s, d, t);
        inside_cnt = '0;
        phase = PH_FWD;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_span(result_t got);
      result_t want;
      if (spans_due.size() == 0) begin
        report($sformatf("span with no item pending, kind %0d", got.kind));
      end else begin
        want = spans_due.pop_front();
        if (got.kind != want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.start != want.start)
          report($sformatf("start %0h, want %0h", got.start, want.start));
        if (got.duration != want.duration)
          report($sformatf("duration %0h, want %0h", got.duration, want.duration));
        if (got.tag != want.tag)
          report($sformatf("tag %0h, want %0h", got.tag, want.tag));
        if (got.final_flag != want.final_flag)
          report($sformatf("final %0b, want %0b", got.final_flag, want.final_flag));
        if (got.overflow != want.overflow)
          report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic is_forward = 1'b0;
  logic [TIME_BITS-1:0] node_start = '0;
  logic [TIME_BITS-1:0] node_duration = '0;
  logic [TAG_BITS-1:0] node_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [TIME_BITS-1:0] out_start;
  logic [TIME_BITS-1:0] out_duration;
  logic [TAG_BITS-1:0] out_tag;
  logic out_final;
  logic queue_overflow;

  span_scoreboard sb = new();
  int items_sent = 0;
  bit steady = 1'b0;
  bit rx_steady = 1'b0;

  fwd_bwd_microbatch_grouper uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .is_forward(is_forward),
    .node_start(node_start),
    .node_duration(node_duration),
    .node_tag(node_tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_start(out_start),
    .out_duration(out_duration),
    .out_tag(out_tag),
    .out_final(out_final),
    .queue_overflow(queue_overflow)
  );

  always #1 clk = ~clk;

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic logic [TAG_BITS-1:0] rand_tag();
    logic [31:0] r;
    r = $urandom;
    return r[TAG_BITS-1:0];
  endfunction

  // mostly short times near zero, now and then anywhere in range
  function automatic logic [TIME_BITS-1:0] pick_time();
    logic [TIME_BITS-1:0] v;
    if ($urandom_range(0, 3) == 0) v = rand_time();
    else v = TIME_BITS'($urandom_range(0, 5000));
    return v;
  endfunction

  task automatic send_item(logic cmd, logic fwd, logic [TIME_BITS-1:0] s,
                           logic [TIME_BITS-1:0] d, logic [TAG_BITS-1:0] t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    is_forward <= fwd;
    node_start <= s;
    node_duration <= d;
    node_tag <= t;
    do @(posedge clk); while (!in_ready);
    sb.predict_span(cmd, fwd, s, d, t);
    items_sent++;
  endtask

  task automatic run_directed();
    send_item(1'b1, 1'b1, T_MAX, T_MAX, 16'hffff);  // finish with nothing held
    send_item(1'b0, 1'b0, T_MAX, T_MAX, 16'hffff);  // backward at init is dropped
    send_item(1'b0, 1'b1, 100, 1000, 16'h0001);
    send_item(1'b0, 1'b0, 100, 1000, 16'h0002);     // touches both span edges
    send_item(1'b0, 1'b0, 1100, 0, 16'h0003);
    send_item(1'b0, 1'b0, 500, 1, 16'h0004);
    send_item(1'b0, 1'b0, 99, 1, 16'h0005);         // outside: opens backward span, count 3
    send_item(1'b0, 1'b0, 10, 5, 16'h0006);         // ends before span start: duration 0
    send_item(1'b0, 1'b0, T_MAX, T_MAX, 16'h0007);  // duration clamps at max
    send_item(1'b0, 1'b0, 5, 7, 16'h0008);          // new backward span, queue empty
    send_item(1'b0, 1'b1, T_MAX, T_MAX, 16'h0000);  // span end beyond the time range
    send_item(1'b0, 1'b0, T_MAX, T_MAX, 16'h0009);
    send_item(1'b0, 1'b0, T_MAX, 0, 16'h000a);
    send_item(1'b0, 1'b1, 0, 0, 16'h000b);
    send_item(1'b0, 1'b0, 1, 0, 16'h000c);
    send_item(1'b0, 1'b0, 1, T_MAX, 16'h000d);      // stretch to exactly max
    send_item(1'b0, 1'b0, 2, 2, 16'h000e);
    send_item(1'b0, 1'b0, 3, 3, 16'h000f);          // pop from empty queue
    send_item(1'b1, 1'b0, 0, 0, 16'h1234);          // finish with a span held
    send_item(1'b1, 1'b1, 7, 7, 16'h4321);
  endtask

  task automatic run_queue_overflow();
    int i;
    for (i = 0; i < 20; i++)
      send_item(1'b0, 1'b1, TIME_BITS'(1000 + i), TIME_BITS'($urandom_range(0, 50)),
                rand_tag());
    send_item(1'b0, 1'b0, 0, 1, rand_tag());        // push dropped, pop reads full front
    send_item(1'b0, 1'b0, 2, 3, rand_tag());
    send_item(1'b1, 1'b0, 0, 0, rand_tag());
  endtask

  task automatic run_random(int n);
    int stop_at;
    int r;
    int k;
    int j;
    logic [TIME_BITS-1:0] hs;
    logic [TIME_BITS-1:0] hd;
    logic [63:0] off;
    logic [63:0] dur;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if (r < 3) begin
        send_item(1'b1, 1'($urandom_range(0, 1)), rand_time(), rand_time(), rand_tag());
      end else if (r < 13) begin
        send_item(1'b0, 1'($urandom_range(0, 1)), rand_time(), rand_time(), rand_tag());
      end else if (r < 65) begin
        // forward span followed by backward work nested inside it
        hs = pick_time();
        hd = pick_time();
        send_item(1'b0, 1'b1, hs, hd, rand_tag());
        k = $urandom_range(0, 4);
        for (j = 0; j < k; j++) begin
          off = {16'b0, rand_time()} % ({16'b0, hd} + 64'd1);
          dur = {16'b0, rand_time()} % ({16'b0, hd} - off + 64'd1);
          send_item(1'b0, 1'b0, hs + off[TIME_BITS-1:0], dur[TIME_BITS-1:0], rand_tag());
        end
        if ($urandom_range(0, 3) == 0)
          send_item(1'b0, 1'b0, pick_time(), pick_time(), rand_tag());
      end else begin
        k = $urandom_range(1, 6);
        for (j = 0; j < k; j++) send_item(1'b0, 1'b0, pick_time(), pick_time(), rand_tag());
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    int taken;
    result_t got;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      // long hold-offs let the block fill up and back-pressure the input
      if (taken == 60 || taken == 400 || taken == 800) gap = 150;
      else if (rx_steady) gap = 0;
      else gap = $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind = out_kind;
      got.start = out_start;
      got.duration = out_duration;
      got.tag = out_tag;
      got.final_flag = out_final;
      got.overflow = queue_overflow;
      sb.check_span(got);
      taken++;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_queue_overflow();
    run_random(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (sb.spans_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.spans_due.size() != 0) sb.report("expected span never arrived");
    if (sb.mismatches == 0) begin
      $display("PASS fwd_bwd_microbatch_grouper");
    end else begin
      $display("FAIL fwd_bwd_microbatch_grouper");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL fwd_bwd_microbatch_grouper");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/fbmg_pkg.sv
src/fbmg_ram.sv
src/fbmg_count_fifo.sv
src/fbmg_out_buf.sv
src/fwd_bwd_microbatch_grouper.sv
verif/tb_fwd_bwd_microbatch_grouper.sv
